// ----- hdl/d96_pkg.sv -----
package d96_pkg;

    localparam int MANT_W = 96;
    localparam int SCALE_W = 5;
    localparam int MAX_SCALE = 28;
    localparam int REM_W = MANT_W + 4;
    localparam int CNT_W = 7;

    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_OVF_POS = 2'd1;
    localparam logic [1:0] ST_OVF_NEG = 2'd2;
    localparam logic [1:0] ST_DIV_ZERO = 2'd3;

    // 2^96 / 10 rounded half to even.
    localparam logic [MANT_W-1:0] CARRY_MANT = 96'h1999_9999_9999_9999_9999_999A;

    typedef struct packed {
        logic [REM_W-1:0] diff;
        logic             ge;
    } alu_res_t;

endpackage

// ----- hdl/d96_alu.sv -----
module d96_alu
(
    input  logic [d96_pkg::REM_W-1:0] a,
    input  logic [d96_pkg::REM_W-1:0] b,
    output d96_pkg::alu_res_t         res
);

    logic [d96_pkg::REM_W:0] wide;

    // One wide subtract; the borrow tells whether a >= b.
    assign wide = {1'b0, a} - {1'b0, b};
    assign res.diff = wide[d96_pkg::REM_W-1:0];
    assign res.ge = ~wide[d96_pkg::REM_W];

endmodule

// ----- hdl/decimal96_divide_top.sv -----
// Signed 96-bit decimal divider with round half to even. One item is taken at a
// time: in_stall stays high from acceptance until the result item is taken.
// An item passes a divisor check, restoring binary division for the integer
// quotient, then up to 56 decimal digits (up to 28 to bring the scale to zero
// and up to 28 more), each made by scaling the remainder by ten, up to nine
// trial subtracts plus a step that settles the digit, and an append; then the
// rounding digit and the rounding itself. The binary division and the trial
// subtracts share the single 100-bit subtract unit. A zero divisor goes from
// the divisor check straight to the result item.
module decimal96_divide_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [63:0] dividend_low,
    input  logic [31:0] dividend_high,
    input  logic [4:0]  dividend_scale,
    input  logic        dividend_negative,
    input  logic [63:0] divisor_low,
    input  logic [31:0] divisor_high,
    input  logic [4:0]  divisor_scale,
    input  logic        divisor_negative,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [63:0] quotient_low,
    output logic [31:0] quotient_high,
    output logic [4:0]  quotient_scale,
    output logic        quotient_negative,
    output logic [1:0]  status
);

    localparam int RW = d96_pkg::REM_W;
    localparam int MW = d96_pkg::MANT_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_INT,
        S_MUL,
        S_SUB,
        S_APPEND,
        S_ROUND,
        S_DONE
    } state_t;

    state_t state_reg;
    logic [MW-1:0] a_reg, b_reg;
    logic [RW-1:0] r_reg, t_reg;
    logic [RW-1:0] q_reg, qt_reg;
    logic [d96_pkg::CNT_W-1:0] cnt_reg;
    logic [3:0] dig_reg;
    logic signed [6:0] scale_reg;
    logic neg_reg, need_reg, rest_reg, tail_reg;
    logic [3:0] d_reg;
    logic out_valid_reg;
    logic [63:0] ql_reg;
    logic [31:0] qh_reg;
    logic [4:0] qs_reg;
    logic qn_reg;
    logic [1:0] st_reg;

    logic [RW-1:0] alu_a;
    logic [RW-1:0] r_shift;
    d96_pkg::alu_res_t alu_res;

    assign r_shift = {r_reg[RW-2:0], a_reg[MW-1]};
    assign alu_a = (state_reg == S_INT) ? r_shift : t_reg;

    d96_alu u_alu
    (
        .a   (alu_a),
        .b   ({4'd0, b_reg}),
        .res (alu_res)
    );

    logic [4:0] sa, sb;
    assign sa = (dividend_scale > 5'(d96_pkg::MAX_SCALE)) ? 5'(d96_pkg::MAX_SCALE)
                                                           : dividend_scale;
    assign sb = (divisor_scale > 5'(d96_pkg::MAX_SCALE)) ? 5'(d96_pkg::MAX_SCALE)
                                                          : divisor_scale;

    logic [RW-1:0] q10;
    logic fits;
    logic inc_mant;
    logic [RW-1:0] q_inc;
    assign q10 = (q_reg << 3) + (q_reg << 1) + {{(RW-4){1'b0}}, dig_reg};
    assign fits = (qt_reg[RW-1:MW] == '0);
    assign inc_mant = (d_reg > 4'd5)
                   || (d_reg == 4'd5 && (rest_reg || q_reg[0]));
    assign q_inc = q_reg + {{(RW-1){1'b0}}, 1'b1};

    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign quotient_low = ql_reg;
    assign quotient_high = qh_reg;
    assign quotient_scale = qs_reg;
    assign quotient_negative = qn_reg;
    assign status = st_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        a_reg <= {dividend_high, dividend_low};
                        b_reg <= {divisor_high, divisor_low};
                        scale_reg <= 7'(sa) - 7'(sb);
                        neg_reg <= dividend_negative ^ divisor_negative;
                        r_reg <= '0;
                        q_reg <= '0;
                        cnt_reg <= '0;
                        need_reg <= 1'b0;
                        tail_reg <= 1'b0;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    if (b_reg == '0)
                    begin
                        ql_reg <= '0;
                        qh_reg <= '0;
                        qs_reg <= '0;
                        qn_reg <= 1'b0;
                        st_reg <= d96_pkg::ST_DIV_ZERO;
                        out_valid_reg <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_INT;
                    end
                end
                S_INT:
                begin
                    r_reg <= alu_res.ge ? alu_res.diff : r_shift;
                    q_reg <= {q_reg[RW-2:0], alu_res.ge};
                    a_reg <= {a_reg[MW-2:0], 1'b0};
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 7'(MW - 1))
                    begin
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    // Decide whether another digit is wanted at all.
                    if (scale_reg >= 0
                        && (r_reg == '0 || scale_reg >= 7'(d96_pkg::MAX_SCALE)))
                    begin
                        state_reg <= S_ROUND;
                    end
                    else
                    begin
                        t_reg <= (r_reg << 3) + (r_reg << 1);
                        dig_reg <= '0;
                        state_reg <= S_SUB;
                    end
                end
                S_SUB:
                begin
                    if (dig_reg < 4'd9 && alu_res.ge)
                    begin
                        t_reg <= alu_res.diff;
                        dig_reg <= dig_reg + 1'b1;
                    end
                    else
                    begin
                        qt_reg <= q10;
                        state_reg <= tail_reg ? S_ROUND : S_APPEND;
                        if (tail_reg)
                        begin
                            d_reg <= dig_reg;
                            rest_reg <= (t_reg != '0);
                            need_reg <= 1'b1;
                        end
                    end
                end
                S_APPEND:
                begin
                    if (!fits)
                    begin
                        if (scale_reg < 0)
                        begin
                            ql_reg <= '0;
                            qh_reg <= '0;
                            qs_reg <= '0;
                            qn_reg <= 1'b0;
                            st_reg <= neg_reg ? d96_pkg::ST_OVF_NEG
                                              : d96_pkg::ST_OVF_POS;
                            out_valid_reg <= 1'b1;
                            state_reg <= S_DONE;
                        end
                        else
                        begin
                            d_reg <= dig_reg;
                            rest_reg <= (t_reg != '0);
                            need_reg <= 1'b1;
                            state_reg <= S_ROUND;
                        end
                    end
                    else
                    begin
                        q_reg <= qt_reg;
                        r_reg <= t_reg;
                        scale_reg <= scale_reg + 7'sd1;
                        state_reg <= S_MUL;
                    end
                end
                S_ROUND:
                begin
                    if (!need_reg && r_reg != '0)
                    begin
                        // One extra digit only for the rounding decision.
                        tail_reg <= 1'b1;
                        t_reg <= (r_reg << 3) + (r_reg << 1);
                        dig_reg <= '0;
                        state_reg <= S_SUB;
                    end
                    else
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg <= S_DONE;
                        if (!(need_reg && inc_mant))
                        begin
                            st_reg <= d96_pkg::ST_OK;
                            ql_reg <= q_reg[63:0];
                            qh_reg <= q_reg[MW-1:64];
                            qs_reg <= scale_reg[4:0];
                            qn_reg <= (q_reg != '0) & neg_reg;
                        end
                        else if (q_inc[RW-1:MW] == '0)
                        begin
                            st_reg <= d96_pkg::ST_OK;
                            ql_reg <= q_inc[63:0];
                            qh_reg <= q_inc[MW-1:64];
                            qs_reg <= scale_reg[4:0];
                            qn_reg <= neg_reg;
                        end
                        else if (scale_reg > 0)
                        begin
                            st_reg <= d96_pkg::ST_OK;
                            ql_reg <= d96_pkg::CARRY_MANT[63:0];
                            qh_reg <= d96_pkg::CARRY_MANT[MW-1:64];
                            qs_reg <= 5'(scale_reg - 7'sd1);
                            qn_reg <= neg_reg;
                        end
                        else
                        begin
                            ql_reg <= '0;
                            qh_reg <= '0;
                            qs_reg <= '0;
                            qn_reg <= 1'b0;
                            st_reg <= neg_reg ? d96_pkg::ST_OVF_NEG
                                              : d96_pkg::ST_OVF_POS;
                        end
                    end
                end
                S_DONE:
                begin
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_busy_no_out: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("result shown while idle");
    a_zero_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status != d96_pkg::ST_OK) |->
        (quotient_low == '0 && quotient_high == '0 && !quotient_negative))
        else $error("error result carries a mantissa");
    a_scale_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> quotient_scale <= 5'(d96_pkg::MAX_SCALE))
        else $error("scale out of range");
`endif

endmodule
